### rtl/core/iot_pkg.sv
// ----------------------------------------------------------------------------
// iot_pkg
// Shared constants, operand tables and class codes for the interval
// orientation test pipeline.
// ----------------------------------------------------------------------------
package iot_pkg;

  // Every coordinate field on the ports is sixteen bits wide.
  localparam int unsigned FIELD_W    = 16;
  localparam int unsigned NUM_FIELDS = 12;
  localparam int unsigned NUM_AXES   = 6;
  localparam int unsigned NUM_DIFFS  = 6;
  localparam int unsigned NUM_PRODS  = 4;
  localparam int unsigned NUM_ENDS   = 4;
  localparam int unsigned TURN_W     = 3;
  localparam int unsigned ALIGN_W    = 2;

  // Coordinate axes in port order: a.x, a.y, b.x, b.y, c.x, c.y.
  localparam int unsigned AX_AX = 0;
  localparam int unsigned AX_AY = 1;
  localparam int unsigned AX_BX = 2;
  localparam int unsigned AX_BY = 3;
  localparam int unsigned AX_CX = 4;
  localparam int unsigned AX_CY = 5;

  // Difference intervals.
  localparam int unsigned D_BYA = 0;  // b.y - a.y
  localparam int unsigned D_CXB = 1;  // c.x - b.x
  localparam int unsigned D_BXA = 2;  // b.x - a.x
  localparam int unsigned D_CYB = 3;  // c.y - b.y
  localparam int unsigned D_CYA = 4;  // c.y - a.y
  localparam int unsigned D_CXA = 5;  // c.x - a.x

  localparam int unsigned DIFF_MIN [NUM_DIFFS] = '{AX_BY, AX_CX, AX_BX, AX_CY, AX_CY, AX_CX};
  localparam int unsigned DIFF_SUB [NUM_DIFFS] = '{AX_AY, AX_BX, AX_AX, AX_BY, AX_AY, AX_AX};

  // Products 0 and 1 form the turn value, products 2 and 3 the alignment value.
  localparam int unsigned PROD_A [NUM_PRODS] = '{D_BYA, D_BXA, D_BXA, D_BYA};
  localparam int unsigned PROD_B [NUM_PRODS] = '{D_CXB, D_CYB, D_CYA, D_CXA};

  typedef enum logic [TURN_W-1:0] {
    TURN_EMPTY    = 3'd0,
    TURN_COLINEAR = 3'd1,
    TURN_UNKNOWN  = 3'd2,
    TURN_CCW      = 3'd3,
    TURN_CW       = 3'd4
  } turn_class_e;

  typedef enum logic [ALIGN_W-1:0] {
    ALIGN_TRUE    = 2'd0,
    ALIGN_FALSE   = 2'd1,
    ALIGN_UNKNOWN = 2'd2
  } align_class_e;

  // Register stages between the input and output ports.
  localparam int unsigned PIPE_DEPTH = 4;

endpackage

### rtl/core/iot_sub.sv
// ----------------------------------------------------------------------------
// iot_sub
// Stage one: coordinate extension, empty interval detection and the six
// interval differences.
// ----------------------------------------------------------------------------
module iot_sub #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  logic [iot_pkg::FIELD_W-1:0]          coord_i [iot_pkg::NUM_FIELDS],
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output logic                                 empty_o,
  output logic signed [COORD_WIDTH:0]          dlo_o [iot_pkg::NUM_DIFFS],
  output logic signed [COORD_WIDTH:0]          dhi_o [iot_pkg::NUM_DIFFS]
);
  import iot_pkg::*;

  logic signed [COORD_WIDTH-1:0] lo_c [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] hi_c [NUM_AXES];
  logic [NUM_AXES-1:0]           bad_ax;
  logic                          valid_q;
  logic                          empty_q;
  logic signed [COORD_WIDTH:0]   dlo_q [NUM_DIFFS];
  logic signed [COORD_WIDTH:0]   dhi_q [NUM_DIFFS];

  // Narrow coordinates take the low bits of the field as two's complement;
  // wide ones see the field as an unsigned value.
  for (genvar k = 0; k < NUM_AXES; k++) begin : g_ext
    if (COORD_WIDTH <= FIELD_W) begin : g_narrow
      assign lo_c[k] = coord_i[2*k][COORD_WIDTH-1:0];
      assign hi_c[k] = coord_i[2*k+1][COORD_WIDTH-1:0];
    end else begin : g_wide
      assign lo_c[k] = {{(COORD_WIDTH-FIELD_W){1'b0}}, coord_i[2*k]};
      assign hi_c[k] = {{(COORD_WIDTH-FIELD_W){1'b0}}, coord_i[2*k+1]};
    end
    assign bad_ax[k] = lo_c[k] > hi_c[k];
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      empty_q <= |bad_ax;
      for (int unsigned d = 0; d < NUM_DIFFS; d++) begin
        dlo_q[d] <= (COORD_WIDTH+1)'(lo_c[DIFF_MIN[d]]) - (COORD_WIDTH+1)'(hi_c[DIFF_SUB[d]]);
        dhi_q[d] <= (COORD_WIDTH+1)'(hi_c[DIFF_MIN[d]]) - (COORD_WIDTH+1)'(lo_c[DIFF_SUB[d]]);
      end
    end
  end

  assign valid_o = valid_q;
  assign empty_o = empty_q;
  assign dlo_o   = dlo_q;
  assign dhi_o   = dhi_q;

endmodule

### rtl/core/iot_mul.sv
// ----------------------------------------------------------------------------
// iot_mul
// Stage two: the four endpoint products of each of the four interval
// products, sixteen signed multipliers in parallel.
// ----------------------------------------------------------------------------
module iot_mul #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  logic                                 empty_i,
  input  logic signed [COORD_WIDTH:0]          dlo_i [iot_pkg::NUM_DIFFS],
  input  logic signed [COORD_WIDTH:0]          dhi_i [iot_pkg::NUM_DIFFS],
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output logic                                 empty_o,
  output logic signed [2*COORD_WIDTH+1:0]      prod_o [iot_pkg::NUM_PRODS][iot_pkg::NUM_ENDS]
);
  import iot_pkg::*;

  localparam int unsigned PW = 2*COORD_WIDTH + 2;

  logic signed [PW-1:0] prod_d [NUM_PRODS][NUM_ENDS];
  logic signed [PW-1:0] prod_q [NUM_PRODS][NUM_ENDS];
  logic                 valid_q;
  logic                 empty_q;

  // Endpoint order: lo*lo, lo*hi, hi*lo, hi*hi.
  for (genvar p = 0; p < NUM_PRODS; p++) begin : g_prod
    assign prod_d[p][0] = PW'(dlo_i[PROD_A[p]]) * PW'(dlo_i[PROD_B[p]]);
    assign prod_d[p][1] = PW'(dlo_i[PROD_A[p]]) * PW'(dhi_i[PROD_B[p]]);
    assign prod_d[p][2] = PW'(dhi_i[PROD_A[p]]) * PW'(dlo_i[PROD_B[p]]);
    assign prod_d[p][3] = PW'(dhi_i[PROD_A[p]]) * PW'(dhi_i[PROD_B[p]]);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      empty_q <= empty_i;
      prod_q  <= prod_d;
    end
  end

  assign valid_o = valid_q;
  assign empty_o = empty_q;
  assign prod_o  = prod_q;

endmodule

### rtl/core/iot_hull.sv
// ----------------------------------------------------------------------------
// iot_hull
// Stage three: the bounds of each interval product, as the minimum and
// maximum of its four endpoint products.
// ----------------------------------------------------------------------------
module iot_hull #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  logic                                 empty_i,
  input  logic signed [2*COORD_WIDTH+1:0]      prod_i [iot_pkg::NUM_PRODS][iot_pkg::NUM_ENDS],
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output logic                                 empty_o,
  output logic signed [2*COORD_WIDTH+1:0]      plo_o [iot_pkg::NUM_PRODS],
  output logic signed [2*COORD_WIDTH+1:0]      phi_o [iot_pkg::NUM_PRODS]
);
  import iot_pkg::*;

  localparam int unsigned PW = 2*COORD_WIDTH + 2;

  logic signed [PW-1:0] min01 [NUM_PRODS];
  logic signed [PW-1:0] min23 [NUM_PRODS];
  logic signed [PW-1:0] max01 [NUM_PRODS];
  logic signed [PW-1:0] max23 [NUM_PRODS];
  logic signed [PW-1:0] plo_d [NUM_PRODS];
  logic signed [PW-1:0] phi_d [NUM_PRODS];
  logic signed [PW-1:0] plo_q [NUM_PRODS];
  logic signed [PW-1:0] phi_q [NUM_PRODS];
  logic                 valid_q;
  logic                 empty_q;

  for (genvar p = 0; p < NUM_PRODS; p++) begin : g_hull
    assign min01[p] = (prod_i[p][1] < prod_i[p][0]) ? prod_i[p][1] : prod_i[p][0];
    assign min23[p] = (prod_i[p][3] < prod_i[p][2]) ? prod_i[p][3] : prod_i[p][2];
    assign max01[p] = (prod_i[p][1] > prod_i[p][0]) ? prod_i[p][1] : prod_i[p][0];
    assign max23[p] = (prod_i[p][3] > prod_i[p][2]) ? prod_i[p][3] : prod_i[p][2];
    assign plo_d[p] = (min23[p] < min01[p]) ? min23[p] : min01[p];
    assign phi_d[p] = (max23[p] > max01[p]) ? max23[p] : max01[p];
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      empty_q <= empty_i;
      plo_q   <= plo_d;
      phi_q   <= phi_d;
    end
  end

  assign valid_o = valid_q;
  assign empty_o = empty_q;
  assign plo_o   = plo_q;
  assign phi_o   = phi_q;

endmodule

### rtl/core/iot_cls.sv
// ----------------------------------------------------------------------------
// iot_cls
// Stage four: interval subtraction of the product pairs and classification
// of the turn and alignment intervals into the output register.
// ----------------------------------------------------------------------------
module iot_cls #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  logic                                 empty_i,
  input  logic signed [2*COORD_WIDTH+1:0]      plo_i [iot_pkg::NUM_PRODS],
  input  logic signed [2*COORD_WIDTH+1:0]      phi_i [iot_pkg::NUM_PRODS],
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output iot_pkg::turn_class_e                 turn_o,
  output iot_pkg::align_class_e                align_o
);
  import iot_pkg::*;

  localparam int unsigned SW = 2*COORD_WIDTH + 3;

  logic signed [SW-1:0] t_lo, t_hi, a_lo, a_hi;
  turn_class_e          turn_d, turn_q;
  align_class_e         align_d, align_q;
  logic                 valid_q;

  assign t_lo = SW'(plo_i[0]) - SW'(phi_i[1]);
  assign t_hi = SW'(phi_i[0]) - SW'(plo_i[1]);
  assign a_lo = SW'(plo_i[2]) - SW'(phi_i[3]);
  assign a_hi = SW'(phi_i[2]) - SW'(plo_i[3]);

  always_comb begin
    if (empty_i) begin
      turn_d  = TURN_EMPTY;
      align_d = ALIGN_FALSE;
    end else begin
      if (t_lo == '0 && t_hi == '0) begin
        turn_d = TURN_COLINEAR;
      end else if (t_lo <= 0 && t_hi >= 0) begin
        turn_d = TURN_UNKNOWN;
      end else if (t_lo > 0) begin
        turn_d = TURN_CCW;
      end else begin
        turn_d = TURN_CW;
      end
      if (a_lo == '0 && a_hi == '0) begin
        align_d = ALIGN_TRUE;
      end else if (a_lo > 0 || a_hi < 0) begin
        align_d = ALIGN_FALSE;
      end else begin
        align_d = ALIGN_UNKNOWN;
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      turn_q  <= turn_d;
      align_q <= align_d;
    end
  end

  assign valid_o = valid_q;
  assign turn_o  = turn_q;
  assign align_o = align_q;

endmodule

### rtl/core/interval_orientation_test.sv
// ----------------------------------------------------------------------------
// interval_orientation_test
// Orientation and alignment classes of three points with interval
// coordinates, computed with exact interval arithmetic.
// ----------------------------------------------------------------------------
// The block takes one point triple per cycle while in_ready_o is high and
// returns one result beat per triple, in order. The four register stages are
// the interval differences, sixteen parallel endpoint multipliers of
// COORD_WIDTH+1 bits, the min/max of each product, then subtraction and
// classification. Each stage holds one beat and moves on its own, so up to
// four beats are in flight and a stalled output only blocks the input once
// every stage is full.
module interval_orientation_test #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [iot_pkg::FIELD_W-1:0]    a_x_low_i,
  input  logic [iot_pkg::FIELD_W-1:0]    a_x_high_i,
  input  logic [iot_pkg::FIELD_W-1:0]    a_y_low_i,
  input  logic [iot_pkg::FIELD_W-1:0]    a_y_high_i,
  input  logic [iot_pkg::FIELD_W-1:0]    b_x_low_i,
  input  logic [iot_pkg::FIELD_W-1:0]    b_x_high_i,
  input  logic [iot_pkg::FIELD_W-1:0]    b_y_low_i,
  input  logic [iot_pkg::FIELD_W-1:0]    b_y_high_i,
  input  logic [iot_pkg::FIELD_W-1:0]    c_x_low_i,
  input  logic [iot_pkg::FIELD_W-1:0]    c_x_high_i,
  input  logic [iot_pkg::FIELD_W-1:0]    c_y_low_i,
  input  logic [iot_pkg::FIELD_W-1:0]    c_y_high_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [iot_pkg::TURN_W-1:0]     turn_class_o,
  output logic [iot_pkg::ALIGN_W-1:0]    aligned_class_o
);
  import iot_pkg::*;

  localparam int unsigned PW = 2*COORD_WIDTH + 2;

  logic [FIELD_W-1:0]          coord [NUM_FIELDS];
  logic                        s1_valid, s1_ready, s1_empty;
  logic signed [COORD_WIDTH:0] s1_dlo [NUM_DIFFS];
  logic signed [COORD_WIDTH:0] s1_dhi [NUM_DIFFS];
  logic                        s2_valid, s2_ready, s2_empty;
  logic signed [PW-1:0]        s2_prod [NUM_PRODS][NUM_ENDS];
  logic                        s3_valid, s3_ready, s3_empty;
  logic signed [PW-1:0]        s3_plo [NUM_PRODS];
  logic signed [PW-1:0]        s3_phi [NUM_PRODS];
  turn_class_e                 turn;
  align_class_e                align;

  assign coord = '{a_x_low_i, a_x_high_i, a_y_low_i, a_y_high_i,
                   b_x_low_i, b_x_high_i, b_y_low_i, b_y_high_i,
                   c_x_low_i, c_x_high_i, c_y_low_i, c_y_high_i};

  iot_sub #(.COORD_WIDTH(COORD_WIDTH)) u_sub (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .coord_i (coord),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .empty_o (s1_empty),
    .dlo_o   (s1_dlo),
    .dhi_o   (s1_dhi)
  );

  iot_mul #(.COORD_WIDTH(COORD_WIDTH)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .empty_i (s1_empty),
    .dlo_i   (s1_dlo),
    .dhi_i   (s1_dhi),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .empty_o (s2_empty),
    .prod_o  (s2_prod)
  );

  iot_hull #(.COORD_WIDTH(COORD_WIDTH)) u_hull (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .empty_i (s2_empty),
    .prod_i  (s2_prod),
    .valid_o (s3_valid),
    .ready_i (s3_ready),
    .empty_o (s3_empty),
    .plo_o   (s3_plo),
    .phi_o   (s3_phi)
  );

  iot_cls #(.COORD_WIDTH(COORD_WIDTH)) u_cls (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s3_valid),
    .ready_o (s3_ready),
    .empty_i (s3_empty),
    .plo_i   (s3_plo),
    .phi_i   (s3_phi),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .turn_o  (turn),
    .align_o (align)
  );

  assign turn_class_o    = turn;
  assign aligned_class_o = align;

endmodule

### rtl/core/iot_chk.sv
// ----------------------------------------------------------------------------
// iot_chk
// Port-level checks for the interval orientation test: beat accounting
// against the pipeline depth, output hold under stall, empty results.
// ----------------------------------------------------------------------------
module iot_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [iot_pkg::TURN_W-1:0]  turn_class_o,
  input logic [iot_pkg::ALIGN_W-1:0] aligned_class_o
);
  import iot_pkg::*;

  // Beats accepted at the input whose result beat has not left yet.
  logic [2:0] pend_q, pend_d;
  logic       in_beat, out_beat;

  assign in_beat  = in_valid_i && in_ready_o;
  assign out_beat = out_valid_o && out_ready_i;

  always_comb begin
    pend_d = pend_q;
    if (in_beat && !out_beat) begin
      pend_d = pend_q + 3'd1;
    end else if (out_beat && !in_beat) begin
      pend_d = pend_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_no_invented_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 3'd0)
    else $error("result beat with no input beat outstanding");

  a_depth_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'(PIPE_DEPTH))
    else $error("more beats in flight than pipeline stages");

  a_full_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q == 3'(PIPE_DEPTH)) && !out_ready_i |-> !in_ready_o)
    else $error("input accepted while every stage is full and stalled");

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(turn_class_o)
      && $stable(aligned_class_o))
    else $error("stalled result beat changed");

  a_empty_not_aligned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (turn_class_o == TURN_EMPTY) |-> aligned_class_o == ALIGN_FALSE)
    else $error("empty turn class without false alignment");

endmodule

bind interval_orientation_test iot_chk u_iot_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .turn_class_o    (turn_class_o),
  .aligned_class_o (aligned_class_o)
);
